@@ sv/rkv_pkg.sv @@
// ----------------------------------------------------------------------------
// rkv_pkg
// Types and constants shared by the ranked key-value table modules.
// ----------------------------------------------------------------------------
package rkv_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_UPDATE     = 3'd1;
  localparam logic [2:0] OP_INS_OR_UPD = 3'd2;
  localparam logic [2:0] OP_ERASE      = 3'd3;
  localparam logic [2:0] OP_CONTAINS   = 3'd4;
  localparam logic [2:0] OP_GET_KEY    = 3'd5;
  localparam logic [2:0] OP_GET_RANK   = 3'd6;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ABSENT  = 3'd1;
  localparam logic [2:0] ST_PRESENT = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_RANK    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [KEY_BITS-1:0] key;
    logic [VALUE_BITS-1:0] new_value;
    logic [5:0]          rank_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_key;
    logic [31:0] out_value;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cell_state_t;

  typedef struct packed {
    logic                  cmp;
    logic                  ins;
    logic                  ers;
    logic                  upd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cell_ctl_t;

endpackage

@@ sv/rkv_cell.sv @@
// ----------------------------------------------------------------------------
// rkv_cell
// One slot of the sorted row: holds a pair, compares it against the request
// key and shifts left or right with its neighbors on insert and erase.
// ----------------------------------------------------------------------------
module rkv_cell import rkv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctl_t   ctl,
  input  cell_state_t left,
  input  logic        left_ge,
  input  cell_state_t right,
  output cell_state_t state,
  output logic        ge,
  output logic        match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      state.valid <= 1'b0;
      ge          <= 1'b0;
      match       <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        match <= state.valid && (state.key == ctl.key);
        ge    <= !state.valid || (state.key >= ctl.key);
      end
      if (ctl.ins && ge) begin
        if (!left_ge) begin
          state.valid <= 1'b1;
          state.key   <= ctl.key;
          state.value <= ctl.value;
        end else begin
          state <= left;
        end
      end else if (ctl.ers && ge) begin
        state <= right;
      end else if (ctl.upd && match) begin
        state.value <= ctl.value;
      end
    end
  end

endmodule

@@ sv/ranked_key_value_table_top.sv @@
// ----------------------------------------------------------------------------
// ranked_key_value_table_top
// Bounded table of unique key-value pairs with lookup by key and by rank.
// ----------------------------------------------------------------------------
// Pairs live in a row of CAPACITY cells kept sorted by ascending key, valid
// cells packed at the low end, so the pair of rank i sits in cell i. Each
// request passes a compare state, where every cell compares its key with the
// request key in parallel, then an apply state, where the row shifts one place
// (insert or erase) or updates in place and the response register loads.
// A new request is taken only when idle or on the edge that loads a response;
// a held response stops the row until its slot frees. Valid marks clear at
// reset; no clearing pass.
module ranked_key_value_table_top import rkv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t             state, state_next;
  req_t               cur;
  logic [CNT_W-1:0]   count, count_next;
  logic               fire, accept;
  cell_ctl_t          ctl;
  cell_state_t        cells [CAPACITY];
  logic [CAPACITY-1:0] ge_vec, match_vec, valid_vec;

  logic                  found, full, rank_ok;
  logic [KEY_BITS-1:0]   rank_key;
  logic [VALUE_BITS-1:0] rank_value, hit_value;
  rsp_t                  rsp_next;

  assign fire   = (state == S_APPLY) && (!rsp_valid || !rsp_stall);
  assign accept = req_valid && !req_stall;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      cell_state_t left_s, right_s;
      logic        left_ge;
      if (g == 0) begin : g_first
        assign left_s  = '0;
        assign left_ge = 1'b0;
      end else begin : g_mid
        assign left_s  = cells[g-1];
        assign left_ge = ge_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_s = '0;
      end else begin : g_inner
        assign right_s = cells[g+1];
      end
      rkv_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .left    (left_s),
        .left_ge (left_ge),
        .right   (right_s),
        .state   (cells[g]),
        .ge      (ge_vec[g]),
        .match   (match_vec[g])
      );
      assign valid_vec[g] = cells[g].valid;
    end
  endgenerate

  // gather hit and rank pairs
  always_comb begin
    hit_value  = '0;
    rank_key   = '0;
    rank_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        hit_value = hit_value | cells[i].value;
      end
      if (cur.rank_index[IDX_W-1:0] == IDX_W'(i)) begin
        rank_key   = rank_key | cells[i].key;
        rank_value = rank_value | cells[i].value;
      end
    end
  end

  assign found   = |match_vec;
  assign full    = (count == CNT_W'(CAPACITY));
  assign rank_ok = ({1'b0, cur.rank_index} < 7'(count));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (fire) state_next = accept ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and operation decode
  always_comb begin
    req_stall  = !((state == S_IDLE) || fire);
    ctl        = '0;
    ctl.cmp    = (state == S_CMP);
    ctl.key    = cur.key;
    ctl.value  = cur.new_value;
    count_next = count;
    rsp_next   = '0;
    rsp_next.status = ST_OK;
    case (cur.op)
      OP_INSERT: begin
        if (found) begin
          rsp_next.status = ST_PRESENT;
        end else if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          ctl.ins    = fire;
          count_next = count + CNT_W'(1);
        end
      end
      OP_UPDATE: begin
        if (found) ctl.upd = fire;
        else rsp_next.status = ST_ABSENT;
      end
      OP_INS_OR_UPD: begin
        if (found) begin
          ctl.upd = fire;
        end else if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          ctl.ins    = fire;
          count_next = count + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (found) begin
          ctl.ers    = fire;
          count_next = count - CNT_W'(1);
        end else begin
          rsp_next.status = ST_ABSENT;
        end
      end
      OP_CONTAINS: begin
        if (!found) rsp_next.status = ST_ABSENT;
      end
      OP_GET_KEY: begin
        if (found) rsp_next.out_value = 32'(hit_value);
        else rsp_next.status = ST_ABSENT;
      end
      OP_GET_RANK: begin
        if (rank_ok) begin
          rsp_next.out_key   = 32'(rank_key);
          rsp_next.out_value = 32'(rank_value);
        end else begin
          rsp_next.status = ST_RANK;
        end
      end
      default: ;
    endcase
    rsp_next.entry_count = 7'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cur <= req;
    if (fire) rsp <= rsp_next;
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("entry count disagrees with valid cells");

  assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + {{CAPACITY{1'b0}}, 1'b1}))
    else $error("valid cells not packed at low end");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> $onehot0(match_vec))
    else $error("key matched in more than one cell");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> req_stall)
    else $error("request taken during compare");

endmodule
